// ----- rtl/light_level_hysteresis_classifier_top_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the light level hysteresis classifier
// Implication checks, sampled at the rising clock edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef LIGHT_LEVEL_HYSTERESIS_CLASSIFIER_TOP_MACROS_SVH
`define LIGHT_LEVEL_HYSTERESIS_CLASSIFIER_TOP_MACROS_SVH

// The consequent holds in the same cycle as the antecedent.
`define LLHC_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// The consequent holds in the cycle after the antecedent.
`define LLHC_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/llhc_pkg.sv -----
// ----------------------------------------------------------------------------
// Light level hysteresis classifier package
// Field widths, register indexes, light mode codes and shared structs.
// ----------------------------------------------------------------------------
package llhc_pkg;

    localparam int LEVEL_W = 10;
    localparam int DWELL_W = 16;
    localparam int TIME_W  = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_LEVEL     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LOW_LEVEL      = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DARKNESS_LEVEL = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DARK_DWELL     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_BRIGHT_DWELL   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLACKOUT_DWELL = 3'd5;

    // Register reset values.
    localparam logic [LEVEL_W-1:0] RST_HIGH_LEVEL     = 10'd100;
    localparam logic [LEVEL_W-1:0] RST_LOW_LEVEL      = 10'd60;
    localparam logic [LEVEL_W-1:0] RST_DARKNESS_LEVEL = 10'd300;
    localparam logic [DWELL_W-1:0] RST_DARK_DWELL     = 16'd2000;
    localparam logic [DWELL_W-1:0] RST_BRIGHT_DWELL   = 16'd2000;
    localparam logic [DWELL_W-1:0] RST_BLACKOUT_DWELL = 16'd500;

    typedef enum logic [1:0] {
        MODE_UNKNOWN = 2'd0,
        MODE_BRIGHT  = 2'd1,
        MODE_DARK    = 2'd2
    } t_mode;

    typedef struct packed {
        logic [LEVEL_W-1:0] high_level;
        logic [LEVEL_W-1:0] low_level;
        logic [LEVEL_W-1:0] darkness_level;
        logic [DWELL_W-1:0] dark_dwell_ms;
        logic [DWELL_W-1:0] bright_dwell_ms;
        logic [DWELL_W-1:0] blackout_dwell_ms;
    } t_cfg;

    typedef struct packed {
        logic               advance;
        logic [LEVEL_W-1:0] charge_ms;
        logic [TIME_W-1:0]  now_ms;
    } t_step;

    typedef struct packed {
        logic is_dark;
        logic changed;
    } t_res;

endpackage

// ----- rtl/llhc_meas_if.sv -----
// ----------------------------------------------------------------------------
// Measurement channel
// Valid/ready channel that carries one light sensor measurement.
// ----------------------------------------------------------------------------
interface llhc_meas_if;
    import llhc_pkg::*;

    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] charge_ms;
    logic [TIME_W-1:0]  now_ms;

    modport source (output valid, output charge_ms, output now_ms, input ready);
    modport sink   (input valid, input charge_ms, input now_ms, output ready);
endinterface

// ----- rtl/llhc_result_if.sv -----
// ----------------------------------------------------------------------------
// Result channel
// Valid/ready channel that carries one classification result.
// ----------------------------------------------------------------------------
interface llhc_result_if;
    logic valid;
    logic ready;
    logic is_dark;
    logic changed;

    modport source (output valid, output is_dark, output changed, input ready);
    modport sink   (input valid, input is_dark, input changed, output ready);
endinterface

// ----- rtl/light_level_hysteresis_classifier_top.sv -----
// ----------------------------------------------------------------------------
// Light level hysteresis classifier, top level
// Input register, classifier core and result register around one state update.
// ----------------------------------------------------------------------------
//  Channel   Direction  Transfer contents
//  i_meas    in         charge_ms (10 bits), now_ms (32 bits)
//  o_result  out        is_dark (1 bit), changed (1 bit)
//  i_cfg_*   in         register write: index (3 bits), data (16 bits)
//
//  One measurement is accepted per cycle while i_meas.ready is high; its result
//  passes through the input register and then the result register, where it
//  waits for o_result.ready.
//  Synchronous reset clears both valid flags, the light mode and the dwell start.
//  A stalled result holds the result register; the input register still takes
//  one more measurement, after which i_meas.ready drops until the result moves.
// ----------------------------------------------------------------------------
module light_level_hysteresis_classifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    llhc_meas_if.sink                       i_meas,
    llhc_result_if.source                   o_result,
    input  logic                            i_cfg_we,
    input  logic [llhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [llhc_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import llhc_pkg::*;
    `include "light_level_hysteresis_classifier_top_macros.svh"

    t_cfg               w_cfg;
    t_step              w_step;
    t_res               w_res;
    logic               r_in_valid;
    logic [LEVEL_W-1:0] r_in_charge;
    logic [TIME_W-1:0]  r_in_now;
    logic               r_out_valid;
    logic               r_out_dark;
    logic               r_out_changed;
    logic               w_advance;
    logic               w_in_ready;

    // The held item moves on when the result register is free or being emptied.
    assign w_advance  = r_in_valid && (!r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_advance;
    assign i_meas.ready = w_in_ready;

    llhc_cfg_regs u_cfg_regs (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    assign w_step.advance   = w_advance;
    assign w_step.charge_ms = r_in_charge;
    assign w_step.now_ms    = r_in_now;

    llhc_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (w_cfg),
        .i_step  (w_step),
        .o_res   (w_res)
    );

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_meas.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_meas.valid) begin
            r_in_charge <= i_meas.charge_ms;
            r_in_now    <= i_meas.now_ms;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance) begin
            r_out_dark    <= w_res.is_dark;
            r_out_changed <= w_res.changed;
        end
    end

    assign o_result.valid   = r_out_valid;
    assign o_result.is_dark = r_out_dark;
    assign o_result.changed = r_out_changed;

    `LLHC_ASSERT_NXT(a_result_loaded, i_clk, i_rst_n, w_advance, r_out_valid,
                     "result register not loaded after an item")
    `LLHC_ASSERT_IMP(a_empty_ready, i_clk, i_rst_n, !r_in_valid, i_meas.ready,
                     "empty input register refuses a measurement")
    `LLHC_ASSERT_NXT(a_blocked_hold, i_clk, i_rst_n, r_in_valid && !w_advance,
                     r_in_valid && $stable(r_in_now), "blocked measurement lost")
endmodule

// ----- rtl/llhc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// Configuration registers
// Holds the three levels and three dwell times written through the port.
// ----------------------------------------------------------------------------
module llhc_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [llhc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [llhc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output llhc_pkg::t_cfg                o_cfg
);
    import llhc_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write; levels take the low ten bits, unknown indexes are ignored.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_HIGH_LEVEL:     n_cfg.high_level        = i_cfg_data[LEVEL_W-1:0];
                CFG_LOW_LEVEL:      n_cfg.low_level         = i_cfg_data[LEVEL_W-1:0];
                CFG_DARKNESS_LEVEL: n_cfg.darkness_level    = i_cfg_data[LEVEL_W-1:0];
                CFG_DARK_DWELL:     n_cfg.dark_dwell_ms     = i_cfg_data[DWELL_W-1:0];
                CFG_BRIGHT_DWELL:   n_cfg.bright_dwell_ms   = i_cfg_data[DWELL_W-1:0];
                CFG_BLACKOUT_DWELL: n_cfg.blackout_dwell_ms = i_cfg_data[DWELL_W-1:0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    // Register file with its reset values.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.high_level        <= RST_HIGH_LEVEL;
            r_cfg.low_level         <= RST_LOW_LEVEL;
            r_cfg.darkness_level    <= RST_DARKNESS_LEVEL;
            r_cfg.dark_dwell_ms     <= RST_DARK_DWELL;
            r_cfg.bright_dwell_ms   <= RST_BRIGHT_DWELL;
            r_cfg.blackout_dwell_ms <= RST_BLACKOUT_DWELL;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;
endmodule

// ----- rtl/llhc_core.sv -----
// ----------------------------------------------------------------------------
// Classifier core
// Light mode and dwell start registers with the single-pass update logic.
// ----------------------------------------------------------------------------
module llhc_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  llhc_pkg::t_cfg  i_cfg,
    input  llhc_pkg::t_step i_step,
    output llhc_pkg::t_res  o_res
);
    import llhc_pkg::*;
    `include "light_level_hysteresis_classifier_top_macros.svh"

    t_mode              r_mode;
    t_mode              n_mode;
    logic [TIME_W-1:0]  r_dwell_start;
    logic [TIME_W-1:0]  n_dwell_start;
    logic               w_changed;
    logic [TIME_W-1:0]  w_elapsed;
    logic [LEVEL_W:0]   w_level_sum;
    logic [LEVEL_W-1:0] w_mid;
    logic               w_above_high;
    logic               w_below_low;
    logic               w_blackout;
    logic               w_dark_due;
    logic               w_bright_due;

    // Elapsed time wraps modulo 2^32; dwell times compare zero-extended.
    assign w_elapsed    = i_step.now_ms - r_dwell_start;
    assign w_level_sum  = {1'b0, i_cfg.high_level} + {1'b0, i_cfg.low_level};
    assign w_mid        = w_level_sum[LEVEL_W:1];
    assign w_above_high = i_step.charge_ms >= i_cfg.high_level;
    assign w_below_low  = i_step.charge_ms < i_cfg.low_level;
    assign w_blackout   = (i_step.charge_ms >= i_cfg.darkness_level) &&
                          (w_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, i_cfg.blackout_dwell_ms});
    assign w_dark_due   = w_blackout ||
                          (w_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, i_cfg.dark_dwell_ms});
    assign w_bright_due = w_elapsed >= {{(TIME_W-DWELL_W){1'b0}}, i_cfg.bright_dwell_ms};

    // Next mode and dwell start; the timer restarts when the exit condition fails.
    always_comb begin
        n_mode        = r_mode;
        n_dwell_start = r_dwell_start;
        w_changed     = 1'b0;
        case (r_mode)
            MODE_BRIGHT: begin
                if (w_above_high) begin
                    if (w_dark_due) begin
                        n_mode        = MODE_DARK;
                        n_dwell_start = i_step.now_ms;
                        w_changed     = 1'b1;
                    end
                end else begin
                    n_dwell_start = i_step.now_ms;
                end
            end
            MODE_DARK: begin
                if (w_below_low) begin
                    if (w_bright_due) begin
                        n_mode        = MODE_BRIGHT;
                        n_dwell_start = i_step.now_ms;
                        w_changed     = 1'b1;
                    end
                end else begin
                    n_dwell_start = i_step.now_ms;
                end
            end
            default: begin
                // First item after reset classifies at once.
                if ((i_step.charge_ms >= i_cfg.darkness_level) || (i_step.charge_ms >= w_mid)) begin
                    n_mode = MODE_DARK;
                end else begin
                    n_mode = MODE_BRIGHT;
                end
                n_dwell_start = i_step.now_ms;
                w_changed     = 1'b1;
            end
        endcase
    end

    // State registers update only when an item moves into the result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode        <= MODE_UNKNOWN;
            r_dwell_start <= '0;
        end else if (i_step.advance) begin
            r_mode        <= n_mode;
            r_dwell_start <= n_dwell_start;
        end
    end

    assign o_res.is_dark = (n_mode == MODE_DARK);
    assign o_res.changed = w_changed;

    `LLHC_ASSERT_NXT(a_mode_known, i_clk, i_rst_n, i_step.advance, (r_mode == MODE_BRIGHT) || (r_mode == MODE_DARK), "light mode unknown after an item")
    `LLHC_ASSERT_NXT(a_mode_hold, i_clk, i_rst_n, !i_step.advance, $stable(r_mode) && $stable(r_dwell_start), "state moved without an item")
    `LLHC_ASSERT_NXT(a_change_restart, i_clk, i_rst_n, i_step.advance && w_changed, r_dwell_start == $past(i_step.now_ms), "dwell timer not restarted on a change")
endmodule
